[rtl/core/mrc_pkg.sv]
// matte region controller: shared widths, codes, entry type and opcode decode
// no dependencies
`timescale 1ns / 1ps

package mrc_pkg;

  localparam int MATTE_ENTRIES_DEF = 8;
  localparam int X_BITS_DEF        = 10;
  localparam int LINE_PIXELS_DEF   = 768;

  localparam int FUNC_W = 2;
  localparam int IDX_W  = 3;
  localparam int OP_W   = 4;
  localparam int ICF_W  = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENTRY = 2'd0,
    FUNC_ICF   = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [OP_W-1:0] {
    OP_STOP     = 4'b0000,
    OP_ICFA     = 4'b0100,
    OP_ICFB     = 4'b0110,
    OP_CLR      = 4'b1000,
    OP_SET      = 4'b1001,
    OP_ICFA_CLR = 4'b1100,
    OP_ICFA_SET = 4'b1101,
    OP_ICFB_CLR = 4'b1110,
    OP_ICFB_SET = 4'b1111
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ICF_W-1:0] icf;
    logic             sel;
  } entry_t;

  typedef struct packed {
    logic stop;
    logic set_a;
    logic set_b;
    logic flag_wr;
    logic flag_val;
  } op_ctl_t;

  // effect of one chain on the shared icf and flag state
  typedef struct packed {
    logic             fire;
    logic             set_a;
    logic             set_b;
    logic             flag_wr;
    logic             flag_val;
    logic             flag_idx;
    logic [ICF_W-1:0] icf;
  } chain_fx_t;

  function automatic op_ctl_t decode_op(logic [OP_W-1:0] op);
    op_ctl_t c;
    c = '0;
    unique case (op)
      OP_STOP:     c.stop = 1'b1;
      OP_ICFA:     c.set_a = 1'b1;
      OP_ICFB:     c.set_b = 1'b1;
      OP_CLR:      c.flag_wr = 1'b1;
      OP_SET:      begin
        c.flag_wr  = 1'b1;
        c.flag_val = 1'b1;
      end
      OP_ICFA_CLR: begin
        c.set_a   = 1'b1;
        c.flag_wr = 1'b1;
      end
      OP_ICFA_SET: begin
        c.set_a    = 1'b1;
        c.flag_wr  = 1'b1;
        c.flag_val = 1'b1;
      end
      OP_ICFB_CLR: begin
        c.set_b   = 1'b1;
        c.flag_wr = 1'b1;
      end
      OP_ICFB_SET: begin
        c.set_b    = 1'b1;
        c.flag_wr  = 1'b1;
        c.flag_val = 1'b1;
      end
      default:     c = '0;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/mrc_if.sv]
// matte region controller: request and result channel interfaces
// depends on mrc_pkg
`timescale 1ns / 1ps

interface mrc_req_if #(
  parameter int XW = mrc_pkg::X_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [mrc_pkg::FUNC_W-1:0] func;
  logic [mrc_pkg::IDX_W-1:0]  entry_index;
  logic [mrc_pkg::OP_W-1:0]   matte_opcode;
  logic [mrc_pkg::ICF_W-1:0]  icf_value;
  logic                       select_bit;
  logic [XW-1:0]              entry_x;
  logic [XW-1:0]              pixel_x;

  modport source (
    output valid, func, entry_index, matte_opcode, icf_value, select_bit, entry_x, pixel_x,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, matte_opcode, icf_value, select_bit, entry_x, pixel_x,
    output ready
  );
endinterface

interface mrc_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [mrc_pkg::ICF_W-1:0] icf_a;
  logic [mrc_pkg::ICF_W-1:0] icf_b;
  logic                      flag_zero;
  logic                      flag_one;

  modport source (
    output valid, icf_a, icf_b, flag_zero, flag_one,
    input  ready
  );
  modport sink (
    input  valid, icf_a, icf_b, flag_zero, flag_one,
    output ready
  );
endinterface

[rtl/core/matte_region_controller_core.sv]
// matte region controller top: table, two chains, icf/flag state, result register
// depends on mrc_pkg, mrc_if, mrc_table, mrc_chain
// a pixel tick gives its result in the register in the cycle after it is taken
// throughput: one request per cycle while the result register is empty or being drained
// requests are taken while the result register is empty or being drained
// reset: icf values, flags, active bits and mode clear, pointers go to their chain start
`timescale 1ns / 1ps

module matte_region_controller_core #(
  parameter int MATTE_ENTRIES = mrc_pkg::MATTE_ENTRIES_DEF,
  parameter int X_BITS        = mrc_pkg::X_BITS_DEF,
  parameter int LINE_PIXELS   = mrc_pkg::LINE_PIXELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  mrc_req_if.sink   req_i,
  mrc_rsp_if.source rsp_o
);
  import mrc_pkg::*;

  localparam int PTR_W = $clog2(MATTE_ENTRIES + 1);

  logic               two_mattes_q;
  logic [ICF_W-1:0]   icf_a_q, icf_a_d, icf_b_q, icf_b_d;
  logic [1:0]         flags_q, flags_d;
  logic               rsp_valid_q, rsp_valid_d;
  logic [ICF_W-1:0]   rsp_a_q, rsp_b_q;
  logic [1:0]         rsp_flags_q;

  logic               req_acc, tick_acc, icf_acc, entry_acc;
  logic [X_BITS-1:0]  px;
  logic               restart, in_line;
  logic [PTR_W-1:0]   limit0;
  logic [MATTE_ENTRIES-1:0] match, le;
  entry_t             entries [MATTE_ENTRIES];
  entry_t             wr_entry;
  chain_fx_t          fx0, fx1;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_acc     = req_i.valid && req_i.ready;
  assign entry_acc   = req_acc && (req_i.func == FUNC_ENTRY);
  assign icf_acc     = req_acc && (req_i.func == FUNC_ICF);
  assign tick_acc    = req_acc && (req_i.func == FUNC_TICK);

  assign px      = req_i.pixel_x;
  assign restart = (px == '0);
  assign in_line = (32'(px) < LINE_PIXELS);
  assign limit0  = two_mattes_q ? PTR_W'(MATTE_ENTRIES / 2) : PTR_W'(MATTE_ENTRIES);

  assign wr_entry.op  = req_i.matte_opcode;
  assign wr_entry.icf = req_i.icf_value;
  assign wr_entry.sel = req_i.select_bit;

  mrc_table #(
    .N  (MATTE_ENTRIES),
    .XW (X_BITS)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (entry_acc),
    .idx_i     (req_i.entry_index),
    .entry_i   (wr_entry),
    .entry_x_i (req_i.entry_x),
    .pixel_x_i (px),
    .match_o   (match),
    .le_o      (le),
    .entries_o (entries)
  );

  mrc_chain #(
    .N       (MATTE_ENTRIES),
    .RST_PTR (0)
  ) u_chain0 (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick_acc),
    .restart_i    (restart),
    .in_line_i    (in_line),
    .en_i         (1'b1),
    .limit_i      (limit0),
    .flag_fixed_i (two_mattes_q),
    .flag_i       (1'b0),
    .match_i      (match),
    .le_i         (le),
    .entries_i    (entries),
    .fx_o         (fx0)
  );

  mrc_chain #(
    .N       (MATTE_ENTRIES),
    .RST_PTR (MATTE_ENTRIES / 2)
  ) u_chain1 (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick_acc),
    .restart_i    (restart),
    .in_line_i    (in_line),
    .en_i         (two_mattes_q),
    .limit_i      (PTR_W'(MATTE_ENTRIES)),
    .flag_fixed_i (1'b1),
    .flag_i       (1'b1),
    .match_i      (match),
    .le_i         (le),
    .entries_i    (entries),
    .fx_o         (fx1)
  );

  // chain zero applies first so chain one wins on icf
  always_comb begin
    icf_a_d = icf_a_q;
    icf_b_d = icf_b_q;
    flags_d = flags_q;
    if (icf_acc) begin
      if (req_i.select_bit) begin
        icf_b_d = req_i.icf_value;
      end else begin
        icf_a_d = req_i.icf_value;
      end
    end
    if (fx0.set_a)   icf_a_d = fx0.icf;
    if (fx0.set_b)   icf_b_d = fx0.icf;
    if (fx0.flag_wr) flags_d[fx0.flag_idx] = fx0.flag_val;
    if (fx1.set_a)   icf_a_d = fx1.icf;
    if (fx1.set_b)   icf_b_d = fx1.icf;
    if (fx1.flag_wr) flags_d[fx1.flag_idx] = fx1.flag_val;

    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    if (tick_acc) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_mattes_q <= 1'b0;
      icf_a_q      <= '0;
      icf_b_q      <= '0;
      flags_q      <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        two_mattes_q <= cfg_wdata_i;
      end
      icf_a_q     <= icf_a_d;
      icf_b_q     <= icf_b_d;
      flags_q     <= flags_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      rsp_a_q     <= icf_a_d;
      rsp_b_q     <= icf_b_d;
      rsp_flags_q <= flags_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.icf_a     = rsp_a_q;
  assign rsp_o.icf_b     = rsp_b_q;
  assign rsp_o.flag_zero = rsp_flags_q[0];
  assign rsp_o.flag_one  = rsp_flags_q[1];

`ifndef SYNTHESIS
  a_tick_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> rsp_o.valid)
    else $error("tick request without result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_acc && !rsp_o.valid |=> !rsp_o.valid)
    else $error("result without tick request");

  a_chain1_only_two_mattes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fx1.fire |-> two_mattes_q)
    else $error("chain one fired in one-matte mode");

  a_fire_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fx0.fire || fx1.fire) |-> tick_acc && in_line)
    else $error("chain fired outside an in-line tick");
`endif

endmodule

[rtl/core/mrc_table.sv]
// matte region controller: matte entry storage with per-entry x compares
// depends on mrc_pkg
`timescale 1ns / 1ps

module mrc_table #(
  parameter int N  = mrc_pkg::MATTE_ENTRIES_DEF,
  parameter int XW = mrc_pkg::X_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [mrc_pkg::IDX_W-1:0] idx_i,
  input  mrc_pkg::entry_t           entry_i,
  input  logic [XW-1:0]             entry_x_i,
  input  logic [XW-1:0]             pixel_x_i,
  output logic [N-1:0]              match_o,
  output logic [N-1:0]              le_o,
  output mrc_pkg::entry_t           entries_o [N]
);
  import mrc_pkg::*;

  entry_t        ent_q [N];
  logic [XW-1:0] x_q   [N];

  for (genvar i = 0; i < N; i++) begin : g_ent
    always_ff @(posedge clk_i) begin
      if (we_i && (32'(idx_i) == i)) begin
        ent_q[i] <= entry_i;
        x_q[i]   <= entry_x_i;
      end
    end

    assign match_o[i]   = (x_q[i] == pixel_x_i);
    assign le_o[i]      = (x_q[i] <= pixel_x_i);
    assign entries_o[i] = ent_q[i];
  end

endmodule

[rtl/core/mrc_chain.sv]
// matte region controller: one matte chain, pointer and active state
// depends on mrc_pkg
`timescale 1ns / 1ps

module mrc_chain #(
  parameter int N       = mrc_pkg::MATTE_ENTRIES_DEF,
  parameter int RST_PTR = 0,
  localparam int PTR_W  = $clog2(N + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  input  logic             restart_i,
  input  logic             in_line_i,
  input  logic             en_i,
  input  logic [PTR_W-1:0] limit_i,
  input  logic             flag_fixed_i,
  input  logic             flag_i,
  input  logic [N-1:0]     match_i,
  input  logic [N-1:0]     le_i,
  input  mrc_pkg::entry_t  entries_i [N],
  output mrc_pkg::chain_fx_t fx_o
);
  import mrc_pkg::*;

  logic [PTR_W-1:0] ptr_q, ptr_d, ptr_eff, ptr_nxt;
  logic             act_q, act_d, act_eff;
  logic             hit, le_next, fire;
  entry_t           ent;
  op_ctl_t          ctl;

  always_comb begin
    ptr_eff = restart_i ? PTR_W'(RST_PTR) : ptr_q;
    act_eff = restart_i | act_q;
    ptr_nxt = ptr_eff + PTR_W'(1);
    hit     = 1'b0;
    le_next = 1'b0;
    ent     = '0;
    for (int i = 0; i < N; i++) begin
      if (ptr_eff == PTR_W'(i)) begin
        hit = match_i[i];
        ent = entries_i[i];
      end
      if (ptr_nxt == PTR_W'(i)) begin
        le_next = le_i[i];
      end
    end
    ctl  = decode_op(ent.op);
    fire = tick_i && en_i && act_eff && (ptr_eff < limit_i) && in_line_i && hit;

    ptr_d = ptr_q;
    act_d = act_q;
    if (fire) begin
      ptr_d = ptr_nxt;
      act_d = !(ctl.stop || (ptr_nxt >= limit_i) || le_next);
    end else if (tick_i) begin
      ptr_d = ptr_eff;
      act_d = act_eff;
    end

    fx_o.fire     = fire;
    fx_o.set_a    = fire & ctl.set_a;
    fx_o.set_b    = fire & ctl.set_b;
    fx_o.flag_wr  = fire & ctl.flag_wr;
    fx_o.flag_val = ctl.flag_val;
    fx_o.flag_idx = flag_fixed_i ? flag_i : ent.sel;
    fx_o.icf      = ent.icf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= PTR_W'(RST_PTR);
      act_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      act_q <= act_d;
    end
  end

endmodule
